// ----- rtl/core/tcet_pkg.sv -----
package tcet_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int TIME_WIDTH      = 32;
    localparam int COUNT_WIDTH     = 32;
    localparam int FRAC_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int JOBQ_DEPTH      = 2;
    localparam int DIV_CNT_WIDTH   = $clog2(TIME_WIDTH);
    // remainder holds 2*r + num < 3*den
    localparam int REM_WIDTH       = SAMPLE_WIDTH + 3;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [FRAC_WIDTH-1:0] LEVEL_FRACTION_RESET = {1'b1, {(FRAC_WIDTH-1){1'b0}}};

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LEVEL_FRACTION = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REPORT_STOP    = 1'b1;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_RANGE  = 2'd1,
        CMD_FIRST  = 2'd2,
        CMD_DETECT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        JOB_START = 2'd0,
        JOB_STEP  = 2'd1,
        JOB_RISE  = 2'd2,
        JOB_FALL  = 2'd3
    } t_job_kind;

    typedef struct packed {
        logic [1:0]                     command;
        logic [TIME_WIDTH-1:0]          sample_time;
        logic signed [SAMPLE_WIDTH-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic [TIME_WIDTH-1:0]  event_time;
        logic [COUNT_WIDTH-1:0] event_count;
        logic [COUNT_WIDTH-1:0] sample_count;
    } t_out_item;

    typedef struct packed {
        t_job_kind             kind;
        logic [SAMPLE_WIDTH:0] num;
        logic [SAMPLE_WIDTH:0] den;
        logic [TIME_WIDTH-1:0] span;
        logic [TIME_WIDTH-1:0] base;
    } t_job;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

// ----- rtl/core/tcet_jobq.sv -----
module tcet_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcet_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output tcet_pkg::t_job o_data,
    output logic          o_empty
);
    import tcet_pkg::*;

    localparam int PTR_WIDTH = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
    localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(JOBQ_DEPTH - 1);
    localparam logic [PTR_WIDTH:0]   CNT_FULL = (PTR_WIDTH + 1)'(JOBQ_DEPTH);

    t_job                 r_mem [JOBQ_DEPTH];
    logic [PTR_WIDTH-1:0] r_wr_ptr;
    logic [PTR_WIDTH-1:0] r_rd_ptr;
    logic [PTR_WIDTH:0]   r_count;
    logic                 w_wr;
    logic                 w_rd;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/tcet_front.sv -----
module tcet_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  tcet_pkg::t_in_item                  i_item,
    input  logic [tcet_pkg::FRAC_WIDTH-1:0]     i_level_fraction,
    output logic                                o_job_push,
    output tcet_pkg::t_job                      o_job,
    input  logic                                i_job_full
);
    import tcet_pkg::*;

    localparam int SW = SAMPLE_WIDTH;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_EXEC = 5'b00010,
        F_MUL  = 5'b00100,
        F_LVL  = 5'b01000,
        F_PUSH = 5'b10000
    } t_fstate;

    t_fstate                    r_state;
    t_fstate                    n_state;
    t_in_item                   r_item;
    logic signed [SW-1:0]       r_min;
    logic signed [SW-1:0]       r_max;
    logic signed [SW-1:0]       r_level;
    logic signed [SW-1:0]       r_prev_value;
    logic [TIME_WIDTH-1:0]      r_prev_time;
    logic [SW+FRAC_WIDTH:0]     r_prod;

    logic signed [SW-1:0]       w_sample;
    logic                       w_range_ok;
    logic [SW:0]                w_range_d;
    logic [SW:0]                w_level_ext;
    logic [SW:0]                w_s_ext;
    logic [SW:0]                w_p_ext;
    logic [SW:0]                w_l_ext;
    logic                       w_rise;
    logic                       w_fall;

    assign w_sample    = r_item.sample_value;
    assign w_range_ok  = (r_min <= r_max);
    assign w_range_d   = {r_max[SW-1], r_max} - {r_min[SW-1], r_min};
    assign w_level_ext = {r_min[SW-1], r_min} + r_prod[SW+FRAC_WIDTH:FRAC_WIDTH];

    assign w_s_ext = {w_sample[SW-1], w_sample};
    assign w_p_ext = {r_prev_value[SW-1], r_prev_value};
    assign w_l_ext = {r_level[SW-1], r_level};
    assign w_rise  = (w_sample > r_level) && (r_prev_value < r_level);
    assign w_fall  = (w_sample < r_level) && (r_prev_value > r_level);

    assign o_full     = (r_state != F_IDLE);
    assign o_job_push = (r_state == F_PUSH) && !i_job_full;

    always_comb begin
        o_job.span = r_item.sample_time - r_prev_time;
        o_job.base = r_prev_time;
        o_job.num  = w_l_ext - w_p_ext;
        o_job.den  = w_s_ext - w_p_ext;
        if (r_item.command == CMD_FIRST) begin
            o_job.kind = JOB_START;
        end else if (w_rise) begin
            o_job.kind = JOB_RISE;
        end else if (w_fall) begin
            o_job.kind = JOB_FALL;
            o_job.num  = w_p_ext - w_l_ext;
            o_job.den  = w_p_ext - w_s_ext;
        end else begin
            o_job.kind = JOB_STEP;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    n_state = F_EXEC;
                end
            end
            F_EXEC: begin
                case (r_item.command)
                    CMD_CLEAR:  n_state = F_IDLE;
                    CMD_RANGE:  n_state = F_MUL;
                    CMD_FIRST:  n_state = F_MUL;
                    default:    n_state = F_PUSH;
                endcase
            end
            F_MUL: n_state = F_LVL;
            F_LVL: begin
                n_state = (r_item.command == CMD_FIRST) ? F_PUSH : F_IDLE;
            end
            F_PUSH: begin
                if (!i_job_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_push) begin
            r_item <= i_item;
        end
        if (r_state == F_MUL) begin
            r_prod <= w_range_d * i_level_fraction;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_min        <= SAMPLE_MAX;
            r_max        <= SAMPLE_MIN;
            r_level      <= '0;
            r_prev_value <= '0;
            r_prev_time  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_EXEC) begin
                if (r_item.command == CMD_CLEAR) begin
                    r_min <= SAMPLE_MAX;
                    r_max <= SAMPLE_MIN;
                end else if (r_item.command == CMD_RANGE) begin
                    if (w_sample > r_max) begin
                        r_max <= w_sample;
                    end
                    if (w_sample < r_min) begin
                        r_min <= w_sample;
                    end
                end
            end
            // an empty range keeps the old level
            if (r_state == F_LVL && w_range_ok) begin
                r_level <= w_level_ext[SW-1:0];
            end
            if (o_job_push) begin
                r_prev_value <= w_sample;
                r_prev_time  <= r_item.sample_time;
            end
        end
    end

endmodule

// ----- rtl/core/tcet_back.sv -----
module tcet_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_empty,
    output logic                o_job_pop,
    input  tcet_pkg::t_job      i_job,
    input  logic                i_report_stop_edge,
    output logic                o_out_valid,
    output tcet_pkg::t_out_item o_out_item,
    input  logic                i_out_pop
);
    import tcet_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int TW = TIME_WIDTH;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_EMIT = 3'b100
    } t_bstate;

    t_bstate                  r_state;
    t_bstate                  n_state;
    t_job                     r_job;
    logic [TW-1:0]            r_start_time;
    logic [TW-1:0]            r_stop_time;
    logic                     r_start_seen;
    logic [COUNT_WIDTH-1:0]   r_rise_count;
    logic [COUNT_WIDTH-1:0]   r_step_count;
    logic [REM_WIDTH-1:0]     r_rem;
    logic [TW-1:0]            r_quot;
    logic [TW-1:0]            r_span;
    logic [DIV_CNT_WIDTH-1:0] r_cnt;
    logic                     r_out_valid;
    t_out_item                r_out_item;

    logic [REM_WIDTH-1:0]     w_num;
    logic [REM_WIDTH-1:0]     w_den;
    logic [REM_WIDTH-1:0]     w_den2;
    logic [REM_WIDTH-1:0]     w_rem_sh;
    logic [REM_WIDTH-1:0]     w_rem_n;
    logic [1:0]               w_digit;
    logic [TW-1:0]            w_quot_n;
    logic [TW-1:0]            w_cross_time;
    logic                     w_take;
    logic                     w_out_load;

    assign w_take     = (r_state == B_IDLE) && !i_job_empty;
    assign o_job_pop  = w_take;
    assign w_out_load = (r_state == B_EMIT) && (!r_out_valid || i_out_pop);

    // one restoring step: r = 2r + (span bit ? num : 0), then subtract up to 2*den
    assign w_num    = REM_WIDTH'(r_job.num);
    assign w_den    = REM_WIDTH'(r_job.den);
    assign w_den2   = w_den << 1;
    assign w_rem_sh = (r_rem << 1) + (r_span[TW-1] ? w_num : '0);

    always_comb begin
        if (w_rem_sh >= w_den2) begin
            w_rem_n = w_rem_sh - w_den2;
            w_digit = 2'd2;
        end else if (w_rem_sh >= w_den) begin
            w_rem_n = w_rem_sh - w_den;
            w_digit = 2'd1;
        end else begin
            w_rem_n = w_rem_sh;
            w_digit = 2'd0;
        end
    end

    assign w_quot_n     = (r_quot << 1) + TW'(w_digit);
    assign w_cross_time = r_job.base + w_quot_n;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (w_take && (i_job.kind == JOB_RISE ||
                               (i_job.kind == JOB_FALL && r_start_seen))) begin
                    n_state = B_DIV;
                end
            end
            B_DIV: begin
                if (r_cnt == '0) begin
                    n_state = (r_job.kind == JOB_RISE) ? B_IDLE : B_EMIT;
                end
            end
            B_EMIT: begin
                if (w_out_load) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job  <= i_job;
            r_span <= i_job.span;
            r_rem  <= '0;
            r_quot <= '0;
            r_cnt  <= DIV_CNT_WIDTH'(TW - 1);
        end else if (r_state == B_DIV) begin
            r_span <= r_span << 1;
            r_rem  <= w_rem_n;
            r_quot <= w_quot_n;
            r_cnt  <= r_cnt - 1'b1;
        end
        if (r_state == B_DIV && r_cnt == '0) begin
            r_stop_time <= w_cross_time;
        end
        if (w_out_load) begin
            r_out_item.event_time   <= i_report_stop_edge ? r_stop_time : r_start_time;
            r_out_item.event_count  <= r_rise_count;
            r_out_item.sample_count <= r_step_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_start_time <= '0;
            r_start_seen <= 1'b0;
            r_rise_count <= '0;
            r_step_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_take) begin
                case (i_job.kind)
                    JOB_START: begin
                        r_start_time <= '0;
                        r_start_seen <= 1'b0;
                        r_rise_count <= '0;
                        r_step_count <= '0;
                    end
                    JOB_RISE: begin
                        r_start_seen <= 1'b1;
                        r_rise_count <= sat_inc(r_rise_count);
                        r_step_count <= sat_inc(r_step_count);
                    end
                    default: begin
                        r_step_count <= sat_inc(r_step_count);
                    end
                endcase
            end
            if (r_state == B_DIV && r_cnt == '0 && r_job.kind == JOB_RISE) begin
                r_start_time <= w_cross_time;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- rtl/core/threshold_crossing_event_timer.sv -----
// Level-crossing event timer.
// Input queue side: drive i_in_item and raise push; the item transfers on a
// clock edge with push high and full low. Commands: clear range, range sample,
// first detection sample, detection sample.
// Result queue side: while empty is low, o_out_item holds the oldest result;
// raise pop to take it. A result appears only on a falling crossing after a
// rising one in the current detection pass.
// Config: i_cfg_valid with i_cfg_index/i_cfg_data; o_cfg_ready is always high.
// Write only while the block has no work in flight.
// Flow: the front end steps a clear through its execute state, a range
// sample through execute, multiply and level, a first detection sample
// through execute, multiply, level and push, and a detection sample through
// execute and push; push waits while the job queue is full. The back end
// runs a radix-2 interpolation divider: 32 divide steps for a crossing, then
// a transfer into the output register on a reported one; it takes no new
// job until it is done with the last. A two-entry job queue joins the ends.
// When the result is not popped the back end holds in its emit step and the
// front end fills the job queue, then raises full.
// Reset: range empty, level, previous sample and counters zero, queues empty.
module threshold_crossing_event_timer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  tcet_pkg::t_in_item                    i_in_item,
    output logic                                  empty,
    input  logic                                  pop,
    output tcet_pkg::t_out_item                   o_out_item,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tcet_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [tcet_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);
    import tcet_pkg::*;

    logic [FRAC_WIDTH-1:0] r_level_fraction;
    logic                  r_report_stop_edge;
    logic                  w_cfg_wr;

    logic                  w_job_push;
    logic                  w_job_full;
    logic                  w_job_pop;
    logic                  w_job_empty;
    t_job                  w_job_in;
    t_job                  w_job_out;
    logic                  w_out_valid;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign empty       = !w_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_fraction   <= LEVEL_FRACTION_RESET;
            r_report_stop_edge <= 1'b0;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_LEVEL_FRACTION: r_level_fraction   <= i_cfg_data[FRAC_WIDTH-1:0];
                CFG_REPORT_STOP:    r_report_stop_edge <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tcet_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_item           (i_in_item),
        .i_level_fraction (r_level_fraction),
        .o_job_push       (w_job_push),
        .o_job            (w_job_in),
        .i_job_full       (w_job_full)
    );

    tcet_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_empty (w_job_empty)
    );

    tcet_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_job_empty        (w_job_empty),
        .o_job_pop          (w_job_pop),
        .i_job              (w_job_out),
        .i_report_stop_edge (r_report_stop_edge),
        .o_out_valid        (w_out_valid),
        .o_out_item         (o_out_item),
        .i_out_pop          (pop)
    );

    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_job_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_push |-> !w_job_full)
        else $error("job pushed into a full queue");

    a_job_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |-> !w_job_empty)
        else $error("job popped from an empty queue");

    a_cfg_fraction_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && i_cfg_index == CFG_LEVEL_FRACTION)
        |=> r_level_fraction == $past(i_cfg_data[FRAC_WIDTH-1:0]))
        else $error("level fraction write lost");

endmodule

// ----- tb/tb_threshold_crossing_event_timer.sv -----
module tb_threshold_crossing_event_timer;
    timeunit 1ns;
    timeprecision 1ps;

    import tcet_pkg::*;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        push = 1'b0;
    logic                        full;
    t_in_item                    i_in_item = '0;
    logic                        empty;
    logic                        pop = 1'b0;
    t_out_item                   o_out_item;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]   i_cfg_data = '0;

    threshold_crossing_event_timer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    t_in_item  sample_queue[$];
    t_out_item pending_events[$];
    int        items_queued = 0;
    int        errors = 0;
    bit        steady = 1'b0;
    bit        hold_go = 1'b0;
    bit        hold_done = 1'b0;
    int        hold_left = 0;

    // mirror of the block's registers and state
    logic [FRAC_WIDTH-1:0]          cfg_frac = LEVEL_FRACTION_RESET;
    bit                             cfg_stop_edge = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] lo_seen = SAMPLE_MAX;
    logic signed [SAMPLE_WIDTH-1:0] hi_seen = SAMPLE_MIN;
    logic signed [SAMPLE_WIDTH-1:0] thresh = '0;
    logic signed [SAMPLE_WIDTH-1:0] last_value = '0;
    logic [TIME_WIDTH-1:0]          last_time = '0;
    logic [TIME_WIDTH-1:0]          pulse_start = '0;
    bit                             pulse_open = 1'b0;
    logic [COUNT_WIDTH-1:0]         rise_total = '0;
    logic [COUNT_WIDTH-1:0]         step_total = '0;

    function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] c);
        if (&c) return c;
        return c + 1'b1;
    endfunction

    // floor(num * span / den); num < den, so the offset stays inside the span
    function automatic logic [TIME_WIDTH-1:0] cross_offset(input int num,
                                                           input logic [TIME_WIDTH-1:0] span,
                                                           input int den);
        logic [63:0] prod;
        prod = 64'(num) * 64'(span);
        return TIME_WIDTH'(prod / 64'(den));
    endfunction

    task automatic refresh_threshold();
        logic [47:0] prod;
        if (lo_seen <= hi_seen) begin
            prod = 48'(int'(hi_seen) - int'(lo_seen)) * 48'(cfg_frac);
            thresh = SAMPLE_WIDTH'(int'(lo_seen) + int'(prod[47:16]));
        end
    endtask

    task automatic track_sample(input t_in_item it);
        logic signed [SAMPLE_WIDTH-1:0] v;
        logic [TIME_WIDTH-1:0]          span;
        logic [TIME_WIDTH-1:0]          stop_t;
        t_out_item                      ev;
        v = it.sample_value;
        case (t_cmd'(it.command))
            CMD_CLEAR: begin
                lo_seen = SAMPLE_MAX;
                hi_seen = SAMPLE_MIN;
            end
            CMD_RANGE: begin
                if (v > hi_seen) hi_seen = v;
                if (v < lo_seen) lo_seen = v;
                refresh_threshold();
            end
            CMD_FIRST: begin
                refresh_threshold();
                last_value  = v;
                last_time   = it.sample_time;
                pulse_start = '0;
                pulse_open  = 1'b0;
                rise_total  = '0;
                step_total  = '0;
            end
            default: begin
                span = it.sample_time - last_time;
                step_total = count_up(step_total);
                if (v > thresh && last_value < thresh) begin
                    pulse_start = last_time + cross_offset(int'(thresh) - int'(last_value),
                                                           span,
                                                           int'(v) - int'(last_value));
                    pulse_open = 1'b1;
                    rise_total = count_up(rise_total);
                end else if (v < thresh && last_value > thresh && pulse_open) begin
                    stop_t = last_time + cross_offset(int'(last_value) - int'(thresh),
                                                      span,
                                                      int'(last_value) - int'(v));
                    ev.event_time   = cfg_stop_edge ? stop_t : pulse_start;
                    ev.event_count  = rise_total;
                    ev.sample_count = step_total;
                    pending_events.push_back(ev);
                end
                last_value = v;
                last_time  = it.sample_time;
            end
        endcase
    endtask

    task automatic compare_event(input t_out_item got);
        t_out_item want;
        if (pending_events.size() == 0) begin
            $display("%0t: result with none expected: time %0d count %0d samples %0d",
                     $time, got.event_time, got.event_count, got.sample_count);
            errors++;
            return;
        end
        want = pending_events.pop_front();
        if (got.event_time !== want.event_time) begin
            $display("%0t: event_time expected %0d actual %0d",
                     $time, want.event_time, got.event_time);
            errors++;
        end
        if (got.event_count !== want.event_count) begin
            $display("%0t: event_count expected %0d actual %0d",
                     $time, want.event_count, got.event_count);
            errors++;
        end
        if (got.sample_count !== want.sample_count) begin
            $display("%0t: sample_count expected %0d actual %0d",
                     $time, want.sample_count, got.sample_count);
            errors++;
        end
    endtask

    // sender: holds an offered item until it transfers
    always @(posedge i_clk) begin : drive
        logic     nxt_push;
        t_in_item nxt_item;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            nxt_push = push;
            nxt_item = i_in_item;
            if (push && !full) begin
                track_sample(sample_queue.pop_front());
                nxt_push = 1'b0;
            end
            if (!nxt_push && sample_queue.size() != 0 &&
                (steady || $urandom_range(99) >= 21)) begin
                nxt_push = 1'b1;
                nxt_item = sample_queue[0];
            end
            push      <= nxt_push;
            i_in_item <= nxt_item;
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(posedge i_clk) begin : collect
        if (!i_rst_n) begin
            pop       <= 1'b0;
            hold_left <= 0;
        end else begin
            if (pop && !empty) compare_event(o_out_item);
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end else if (hold_go && !hold_done) begin
                hold_left <= 400;
                hold_done <= 1'b1;
                pop       <= 1'b0;
            end else begin
                pop <= steady || ($urandom_range(99) >= 21);
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_LEVEL_FRACTION) cfg_frac = data;
        else cfg_stop_edge = data[0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_item(input t_cmd c, input logic [TIME_WIDTH-1:0] t, input int v);
        t_in_item it;
        it.command      = c;
        it.sample_time  = t;
        it.sample_value = SAMPLE_WIDTH'(v);
        sample_queue.push_back(it);
        items_queued++;
    endtask

    function automatic int any_sample();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic int clamp_sample(input int v);
        if (v > int'(SAMPLE_MAX)) return int'(SAMPLE_MAX);
        if (v < int'(SAMPLE_MIN)) return int'(SAMPLE_MIN);
        return v;
    endfunction

    task automatic add_directed();
        // detection with no first sample: starts from the reset state
        add_item(CMD_DETECT, 32'd5, 100);
        add_item(CMD_DETECT, 32'd10, -100);   // falling before any rising
        add_item(CMD_DETECT, 32'd20, 50);
        add_item(CMD_DETECT, 32'd30, -50);
        add_item(CMD_CLEAR, 32'hFFFF_FFFF, -1);
        add_item(CMD_RANGE, 32'd0, -32768);
        add_item(CMD_RANGE, 32'd0, 32767);
        add_item(CMD_FIRST, 32'hFFFF_FFF0, -32768);
        add_item(CMD_DETECT, 32'h10, 32767);   // time wraps
        add_item(CMD_DETECT, 32'h20, -1);      // lands on the level: no crossing
        add_item(CMD_DETECT, 32'h30, -32768);
        add_item(CMD_DETECT, 32'h40, 32767);
        add_item(CMD_DETECT, 32'hFFFF_FFFF, -32768);
        add_item(CMD_DETECT, 32'h10, 32767);   // time goes backward
        add_item(CMD_DETECT, 32'h10, -32768);  // zero span
        add_item(CMD_CLEAR, 32'd0, 0);
        add_item(CMD_FIRST, 32'd0, 0);         // empty range keeps the level
        add_item(CMD_DETECT, 32'd5, -2);
        add_item(CMD_RANGE, 32'd7, 7);         // single-value range
        add_item(CMD_FIRST, 32'd100, 0);
        add_item(CMD_DETECT, 32'd200, 8);
        add_item(CMD_DETECT, 32'd300, 6);
    endtask

    // one range pass and one detection pass, sometimes broken or mixed with noise
    task automatic add_pass();
        int                    lo, hi, tmp, w, n, i, v;
        logic [TIME_WIDTH-1:0] t;
        if ($urandom_range(9) == 0) begin
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++)
                add_item(t_cmd'($urandom_range(3)), $urandom, any_sample());
        end
        if ($urandom_range(7) == 0) begin
            lo = int'(SAMPLE_MIN);
            hi = int'(SAMPLE_MAX);
        end else begin
            lo = any_sample();
            hi = any_sample();
            if (lo > hi) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
        end
        w = (hi - lo) / 8 + 1;
        if ($urandom_range(5) != 0) add_item(CMD_CLEAR, $urandom, any_sample());
        add_item(CMD_RANGE, $urandom, lo);
        add_item(CMD_RANGE, $urandom, hi);
        n = $urandom_range(3);
        for (i = 0; i < n; i++)
            add_item(CMD_RANGE, $urandom, lo + int'($urandom_range(hi - lo)));
        t = $urandom;
        if ($urandom_range(7) != 0) add_item(CMD_FIRST, t, lo + int'($urandom_range(hi - lo)));
        n = $urandom_range(4, 14);
        for (i = 0; i < n; i++) begin
            t = ($urandom_range(15) == 0) ? $urandom : t + $urandom_range(3000);
            if ($urandom_range(9) == 0)
                v = lo + int'($urandom_range(hi - lo));
            else if (i % 2 == 0)
                v = clamp_sample(hi + int'($urandom_range(64)) -
                                 (($urandom_range(3) == 0) ? int'($urandom_range(w)) : 0));
            else
                v = clamp_sample(lo - int'($urandom_range(64)) +
                                 (($urandom_range(3) == 0) ? int'($urandom_range(w)) : 0));
            add_item(CMD_DETECT, t, v);
        end
    endtask

    // waits until every item has transferred and every result has come back
    task automatic wait_idle();
        do @(posedge i_clk);
        while (sample_queue.size() != 0 || push || pending_events.size() != 0);
        repeat (300) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int                    p, goal;
        logic [FRAC_WIDTH-1:0] frac;
        bit                    stop_edge;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg(CFG_LEVEL_FRACTION, LEVEL_FRACTION_RESET);
        write_reg(CFG_REPORT_STOP, '0);
        add_directed();
        wait_idle();
        for (p = 0; p < 7; p++) begin
            case (p)
                0:       begin frac = '0;       stop_edge = 1'b1; end
                1:       begin frac = '1;       stop_edge = 1'b0; end
                2:       begin frac = 16'h8000; stop_edge = 1'b1; end
                3:       begin frac = 16'd1;    stop_edge = 1'b0; end
                default: begin
                    frac      = FRAC_WIDTH'($urandom);
                    stop_edge = 1'($urandom_range(1));
                end
            endcase
            steady  <= (p == 2);
            hold_go <= (p == 4);
            write_reg(CFG_LEVEL_FRACTION, frac);
            write_reg(CFG_REPORT_STOP, CFG_DATA_WIDTH'(stop_edge));
            goal = items_queued + 50;
            while (items_queued < goal) add_pass();
            wait_idle();
        end
        if (errors == 0 && pending_events.size() == 0) begin
            $display("tb_threshold_crossing_event_timer: done, clean");
        end else begin
            $display("tb_threshold_crossing_event_timer: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb_threshold_crossing_event_timer: done, errors");
        $finish;
    end

endmodule

// ----- threshold_crossing_event_timer.f -----
rtl/core/tcet_pkg.sv
rtl/core/tcet_jobq.sv
rtl/core/tcet_front.sv
rtl/core/tcet_back.sv
rtl/core/threshold_crossing_event_timer.sv
tb/tb_threshold_crossing_event_timer.sv
